// File: src/udgc_pkg.sv
// Shared types, constants and the digit font for the decimal glyph column renderer.
// No dependencies; every other file takes names from here by scope.
package udgc_pkg;

   localparam int VALUE_W       = 32;
   localparam int NIBBLE_W      = 4;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(CONV_STEPS);
   localparam int GLYPH_WIDTH   = 5;
   localparam int COL_W         = $clog2(GLYPH_WIDTH);
   localparam int BYTE_W        = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic slot_free;
      logic final_col;
   } status_type;

   // one column of the glyph for a decimal digit; column 0 is the leftmost
   function automatic logic [BYTE_W-1:0] font_col(input logic [NIBBLE_W-1:0] digit,
                                                 input logic [COL_W-1:0]    col);
      logic [GLYPH_WIDTH*BYTE_W-1:0] row;
      unique case (digit)
         4'd0:    row = {8'h3e, 8'h45, 8'h49, 8'h51, 8'h3e};
         4'd1:    row = {8'h00, 8'h40, 8'h7f, 8'h42, 8'h00};
         4'd2:    row = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         4'd3:    row = {8'h31, 8'h4b, 8'h45, 8'h41, 8'h21};
         4'd4:    row = {8'h10, 8'h7f, 8'h12, 8'h14, 8'h18};
         4'd5:    row = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         4'd6:    row = {8'h30, 8'h49, 8'h49, 8'h4a, 8'h3c};
         4'd7:    row = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         4'd8:    row = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         default: row = {8'h1e, 8'h29, 8'h49, 8'h49, 8'h06};
      endcase
      return row[col*BYTE_W +: BYTE_W];
   endfunction

endpackage

// File: src/udgc_req_if.sv
// Input channel: valid/ready handshake carrying the value to render.
// Depends on udgc_pkg for the value width.
interface udgc_req_if;
   logic                         valid;
   logic                         ready;
   logic [udgc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// File: src/udgc_rsp_if.sv
// Result channel: valid/ready handshake carrying one glyph column byte and last.
// Depends on udgc_pkg for the byte width.
interface udgc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [udgc_pkg::BYTE_W-1:0] column_byte;
   logic                        last;

   modport source (output valid, output column_byte, output last, input ready);
   modport sink   (input valid, input column_byte, input last, output ready);
endinterface

// File: src/udgc_ctrl.sv
// Controller state machine: sequences conversion, leading-digit scan and column output.
// Depends on udgc_pkg for state, command and status types.
module udgc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  udgc_pkg::status_type status,
   output udgc_pkg::cmd_type    cmd
);

   udgc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udgc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         udgc_pkg::ST_IDLE: begin
            if (req_valid) state_in = udgc_pkg::ST_CONV;
         end
         udgc_pkg::ST_CONV: begin
            if (status.conv_done) state_in = udgc_pkg::ST_SCAN;
         end
         udgc_pkg::ST_SCAN: begin
            state_in = udgc_pkg::ST_EMIT;
         end
         udgc_pkg::ST_EMIT: begin
            if (status.slot_free && status.final_col) state_in = udgc_pkg::ST_IDLE;
         end
         default: state_in = udgc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         udgc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         udgc_pkg::ST_CONV: begin
            cmd.shift = 1'b1;
         end
         udgc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         udgc_pkg::ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: src/udgc_datapath.sv
// Datapath: double-dabble BCD conversion, four bits a cycle, digit pointer and
// output register for glyph columns. Depends on udgc_pkg for widths, types and the font.
module udgc_datapath #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [udgc_pkg::VALUE_W-1:0] req_value,
   input  udgc_pkg::cmd_type            cmd,
   output udgc_pkg::status_type         status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [udgc_pkg::BYTE_W-1:0]  rsp_column_byte,
   output logic                         rsp_last
);

   localparam int BCD_W   = MAX_DIGITS * udgc_pkg::NIBBLE_W;
   localparam int DIG_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [udgc_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic                         ovf_ff, ovf_in;
   logic [udgc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [DIG_W-1:0]             dig_ff, dig_in;
   logic [udgc_pkg::COL_W-1:0]   col_ff, col_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [udgc_pkg::BYTE_W-1:0]  rsp_col_ff, rsp_col_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [udgc_pkg::VALUE_W-1:0] bin_sh;
   logic [BCD_W-1:0]             bcd_sh;
   logic                         ovf_sh;
   logic [DIG_W-1:0]             lead;
   logic [udgc_pkg::NIBBLE_W-1:0] cur_digit;
   logic                         final_col;
   logic                         last_col;

   // four shift-and-adjust steps; anything carried out of the top digit means
   // the value has more digits than are kept
   always_comb begin
      bcd_sh = bcd_ff;
      bin_sh = bin_ff;
      ovf_sh = ovf_ff;
      for (int j = 0; j < udgc_pkg::BITS_PER_STEP; j++) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_sh[i*udgc_pkg::NIBBLE_W +: udgc_pkg::NIBBLE_W] >= 4'd5) begin
               bcd_sh[i*udgc_pkg::NIBBLE_W +: udgc_pkg::NIBBLE_W] =
                  bcd_sh[i*udgc_pkg::NIBBLE_W +: udgc_pkg::NIBBLE_W] + 4'd3;
            end
         end
         ovf_sh = ovf_sh | bcd_sh[BCD_W-1];
         bcd_sh = {bcd_sh[BCD_W-2:0], bin_sh[udgc_pkg::VALUE_W-1]};
         bin_sh = {bin_sh[udgc_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   // most significant digit shown; all digits kept once the value overflowed
   always_comb begin
      lead = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*udgc_pkg::NIBBLE_W +: udgc_pkg::NIBBLE_W] != '0) lead = DIG_W'(i);
      end
      if (ovf_ff) lead = DIG_W'(MAX_DIGITS - 1);
   end

   assign cur_digit = bcd_ff[dig_ff*udgc_pkg::NIBBLE_W +: udgc_pkg::NIBBLE_W];
   assign last_col  = (col_ff == udgc_pkg::COL_W'(udgc_pkg::GLYPH_WIDTH - 1));
   assign final_col = last_col && (dig_ff == '0);

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      dig_in       = dig_ff;
      col_in       = col_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.load) begin
         bin_in  = req_value;
         bcd_in  = '0;
         ovf_in  = 1'b0;
         step_in = '0;
      end
      if (cmd.shift) begin
         bin_in  = bin_sh;
         bcd_in  = bcd_sh;
         ovf_in  = ovf_sh;
         step_in = step_ff + 1'b1;
      end
      if (cmd.scan) begin
         dig_in = lead;
         col_in = '0;
      end
      if (cmd.emit) begin
         rsp_col_in   = udgc_pkg::font_col(cur_digit, col_ff);
         rsp_last_in  = final_col;
         rsp_valid_in = 1'b1;
         if (last_col) begin
            col_in = '0;
            dig_in = dig_ff - 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      ovf_ff      <= ovf_in;
      dig_ff      <= dig_in;
      col_ff      <= col_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.conv_done = (step_ff == udgc_pkg::STEP_W'(udgc_pkg::CONV_STEPS - 1));
   assign status.slot_free = ~rsp_valid_ff | rsp_ready;
   assign status.final_col = final_col;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_byte = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/uint_to_decimal_glyph_columns_top.sv
// Decimal glyph column renderer: value in, five font column bytes per decimal digit out.
// The first column byte is registered after the conversion (four bits per step), the
// leading-digit scan and the output load.
// Throughput: one column byte per cycle while the receiver is ready; a new value is taken
// once the last column is loaded.
// Reset (synchronous, active high) clears the controller, the conversion step counter and the output valid flag.
module uint_to_decimal_glyph_columns_top #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   udgc_req_if.sink            req_chan,
   udgc_rsp_if.source          rsp_chan
);

   udgc_pkg::cmd_type    cmd;
   udgc_pkg::status_type status;

   udgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   udgc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_chan.value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_column_byte (rsp_chan.column_byte),
      .rsp_last        (rsp_chan.last)
   );

endmodule
